// ===== hw/rtl/sse_pkg.sv =====
// Shared types, constants and subset position tables for the sorted subset expander.
package sse_pkg;

    localparam int unsigned NumVals   = 5;
    localparam int unsigned ValW      = 8;
    localparam int unsigned RankW     = 3;
    localparam int unsigned IdxW      = 4;
    localparam int unsigned InDataW   = 40;
    localparam int unsigned OutDataW  = 24;

    localparam logic [IdxW-1:0] LastIdx = 4'd9;

    typedef enum logic {
        KIND_PAIR   = 1'b0,
        KIND_TRIPLE = 1'b1
    } t_kind;

    typedef logic [NumVals-1:0][ValW-1:0]  t_vals;
    typedef logic [NumVals-1:0][RankW-1:0] t_ranks;

    typedef struct packed {
        t_kind kind;
        t_vals vals;
    } t_srt;

    typedef struct packed {
        logic [RankW-1:0] p0;
        logic [RankW-1:0] p1;
        logic [RankW-1:0] p2;
    } t_pick;

    function automatic t_pick sse_pair_pos(input logic [IdxW-1:0] idx);
        t_pick p;
        p.p2 = 3'd0;
        case (idx)
            4'd0:    begin p.p0 = 3'd0; p.p1 = 3'd1; end
            4'd1:    begin p.p0 = 3'd0; p.p1 = 3'd2; end
            4'd2:    begin p.p0 = 3'd0; p.p1 = 3'd3; end
            4'd3:    begin p.p0 = 3'd0; p.p1 = 3'd4; end
            4'd4:    begin p.p0 = 3'd1; p.p1 = 3'd2; end
            4'd5:    begin p.p0 = 3'd1; p.p1 = 3'd3; end
            4'd6:    begin p.p0 = 3'd1; p.p1 = 3'd4; end
            4'd7:    begin p.p0 = 3'd2; p.p1 = 3'd3; end
            4'd8:    begin p.p0 = 3'd2; p.p1 = 3'd4; end
            4'd9:    begin p.p0 = 3'd3; p.p1 = 3'd4; end
            default: begin p.p0 = 3'd0; p.p1 = 3'd0; end
        endcase
        return p;
    endfunction

    function automatic t_pick sse_triple_pos(input logic [IdxW-1:0] idx);
        t_pick p;
        case (idx)
            4'd0:    begin p.p0 = 3'd0; p.p1 = 3'd1; p.p2 = 3'd2; end
            4'd1:    begin p.p0 = 3'd0; p.p1 = 3'd1; p.p2 = 3'd3; end
            4'd2:    begin p.p0 = 3'd0; p.p1 = 3'd1; p.p2 = 3'd4; end
            4'd3:    begin p.p0 = 3'd0; p.p1 = 3'd2; p.p2 = 3'd3; end
            4'd4:    begin p.p0 = 3'd0; p.p1 = 3'd2; p.p2 = 3'd4; end
            4'd5:    begin p.p0 = 3'd0; p.p1 = 3'd3; p.p2 = 3'd4; end
            4'd6:    begin p.p0 = 3'd1; p.p1 = 3'd2; p.p2 = 3'd3; end
            4'd7:    begin p.p0 = 3'd1; p.p1 = 3'd2; p.p2 = 3'd4; end
            4'd8:    begin p.p0 = 3'd1; p.p1 = 3'd3; p.p2 = 3'd4; end
            4'd9:    begin p.p0 = 3'd2; p.p1 = 3'd3; p.p2 = 3'd4; end
            default: begin p.p0 = 3'd0; p.p1 = 3'd0; p.p2 = 3'd0; end
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/sorted_subset_expander_unit.sv =====
// Top level of the sorted subset expander: ranking lanes, merge register and subset emitter.
//
// Input channel (s_axis): one transaction carries five byte values in tdata and the
// kind in tuser (0 = pairs, 1 = triples). Output channel (m_axis): each input
// transaction yields ten output transactions, the subsets of the sorted values in
// lexicographic order of position, with tlast on the tenth.
// After the input is accepted, it is registered in the merge register and then in the
// emitter before the first result appears.
// The output channel carries one result per cycle while the receiver keeps tready high;
// the next item is sorted and held while the current one drains, so results stream
// without gaps.
// Reset (i_rst_n low, synchronous) empties both stages; no results are pending after it.
// When the receiver stalls, the current result holds; one further input item may be
// accepted into the merge register, after which s_axis tready stays low.
module sorted_subset_expander_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [sse_pkg::InDataW-1:0]     i_s_axis_tdata,  // value_a..value_e, 8 bits each
    input  logic                            i_s_axis_tuser,  // kind
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [sse_pkg::OutDataW-1:0]    o_m_axis_tdata,  // first, second, third pick
    output logic                            o_m_axis_tlast   // is_last
);
    import sse_pkg::*;

    t_vals  in_vals;
    t_ranks ranks;
    t_srt   srt;
    t_kind  in_kind;
    logic   r_s1_vld;
    logic   n_s1_vld;
    logic   s_fire;
    logic   take;
    logic [ValW-1:0] first_pick;
    logic [ValW-1:0] second_pick;
    logic [ValW-1:0] third_pick;

    assign in_vals = i_s_axis_tdata;
    assign in_kind = t_kind'(i_s_axis_tuser);

    for (genvar g = 0; g < NumVals; g++) begin : g_lane
        sse_rank_lane u_lane (
            .i_vals (in_vals),
            .i_lane (RankW'(g)),
            .o_rank (ranks[g])
        );
    end

    assign o_s_axis_tready = !r_s1_vld || take;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    sse_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (s_fire),
        .i_vals  (in_vals),
        .i_ranks (ranks),
        .i_kind  (in_kind),
        .o_srt   (srt)
    );

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (take) begin
            n_s1_vld = 1'b0;
        end
        if (s_fire) begin
            n_s1_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    sse_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (r_s1_vld),
        .i_srt    (srt),
        .o_take   (take),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_first  (first_pick),
        .o_second (second_pick),
        .o_third  (third_pick),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {third_pick, second_pick, first_pick};

    a_take_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> r_s1_vld)
        else $error("emitter took an empty merge register");

    a_held_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !take) |=> (r_s1_vld && $stable(srt)))
        else $error("sorted set lost before the emitter took it");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !take) |-> !o_s_axis_tready)
        else $error("input accepted over a waiting sorted set");

endmodule

// ===== hw/rtl/sse_rank_lane.sv =====
// One ranking lane: counts how many values sort ahead of this lane's value.
module sse_rank_lane (
    input  sse_pkg::t_vals              i_vals,
    input  logic [sse_pkg::RankW-1:0]   i_lane,
    output logic [sse_pkg::RankW-1:0]   o_rank
);
    import sse_pkg::*;

    logic [ValW-1:0] own;

    always_comb begin
        own    = i_vals[i_lane];
        o_rank = '0;
        for (int j = 0; j < NumVals; j++) begin
            if (RankW'(j) != i_lane) begin
                if ((i_vals[j] < own) || ((i_vals[j] == own) && (RankW'(j) < i_lane))) begin
                    o_rank = o_rank + 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/sse_merge.sv =====
// Merge stage: places each lane's value at its rank and registers the sorted set.
module sse_merge (
    input  logic            i_clk,
    input  logic            i_load,
    input  sse_pkg::t_vals  i_vals,
    input  sse_pkg::t_ranks i_ranks,
    input  sse_pkg::t_kind  i_kind,
    output sse_pkg::t_srt   o_srt
);
    import sse_pkg::*;

    t_srt r_srt;
    t_srt n_srt;

    always_comb begin
        n_srt.kind = i_kind;
        n_srt.vals = '0;
        for (int p = 0; p < NumVals; p++) begin
            for (int i = 0; i < NumVals; i++) begin
                if (i_ranks[i] == RankW'(p)) begin
                    n_srt.vals[p] = n_srt.vals[p] | i_vals[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_srt <= n_srt;
        end
    end

    assign o_srt = r_srt;

endmodule

// ===== hw/rtl/sse_emit.sv =====
// Subset emitter: steps through the ten subsets of a sorted set, one per transaction.
module sse_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_avail,
    input  sse_pkg::t_srt               i_srt,
    output logic                        o_take,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sse_pkg::ValW-1:0]    o_first,
    output logic [sse_pkg::ValW-1:0]    o_second,
    output logic [sse_pkg::ValW-1:0]    o_third,
    output logic                        o_last
);
    import sse_pkg::*;

    t_srt            r_cur;
    logic            r_busy;
    logic [IdxW-1:0] r_idx;
    logic            n_busy;
    logic [IdxW-1:0] n_idx;
    logic            fire;
    logic            at_last;
    t_pick           pick;

    assign at_last = (r_idx == LastIdx);
    assign fire    = r_busy && i_ready;
    assign o_take  = i_avail && (!r_busy || (fire && at_last));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (fire) begin
            if (at_last) begin
                n_busy = 1'b0;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
        if (o_take) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cur <= i_srt;
        end
    end

    always_comb begin
        pick = (r_cur.kind == KIND_TRIPLE) ? sse_triple_pos(r_idx) : sse_pair_pos(r_idx);
    end

    assign o_valid  = r_busy;
    assign o_first  = r_cur.vals[pick.p0];
    assign o_second = r_cur.vals[pick.p1];
    assign o_third  = (r_cur.kind == KIND_TRIPLE) ? r_cur.vals[pick.p2] : '0;
    assign o_last   = at_last;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LastIdx)
        else $error("subset index out of range");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !at_last) |=> (r_busy && (r_idx == $past(r_idx) + 1'b1)))
        else $error("subset index did not advance");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |=> (r_busy && $stable(r_idx)))
        else $error("subset index moved while stalled");

    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_avail) |-> o_take)
        else $error("idle emitter left a sorted set waiting");

endmodule
